// File: sv/bfae_pkg.sv
package bfae_pkg;

    localparam int DATA_W     = 64;
    localparam int OFF_W      = 12;
    localparam int SIZE_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SPAN_W     = 72;
    localparam int NBYTES_W   = 4;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic TARGET_INT  = 1'b0;
    localparam logic TARGET_BYTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_WIDTH = 2'd2;

    localparam logic [8:0] BUF_BYTES_RST = 9'd256;
    localparam logic [6:0] INT_W_RST     = 7'd64;
    localparam logic [6:0] INT_W_MIN     = 7'd32;
    localparam logic [6:0] INT_W_MAX     = 7'd64;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic check;
        logic int_op;
        logic byte_step;
        logic align;
        logic load_out;
    } bfae_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic byte_target;
        logic is_write;
        logic bytes_last;
    } bfae_sts_t;

    function automatic logic [DATA_W-1:0] low_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        if (size >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << size) - 64'd1;
        end
        return m;
    endfunction

endpackage

// File: sv/bfae_ctrl.sv
module bfae_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output bfae_pkg::bfae_cmd_t cmd,
    input  bfae_pkg::bfae_sts_t sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_INT   = 3'd3;
    localparam logic [2:0] S_BYTES = 3'd4;
    localparam logic [2:0] S_ALIGN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (sts.bad) begin
                    state_next = S_DONE;
                end else if (sts.byte_target) begin
                    state_next = S_BYTES;
                end else begin
                    state_next = S_INT;
                end
            end
            S_INT: begin
                cmd.int_op = 1'b1;
                state_next = S_DONE;
            end
            S_BYTES: begin
                cmd.byte_step = 1'b1;
                if (sts.bytes_last) begin
                    state_next = sts.is_write ? S_DONE : S_ALIGN;
                end
            end
            S_ALIGN: begin
                cmd.align  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sv/bfae_dp.sv
module bfae_dp #(
    parameter int BUFFER_DEPTH = bfae_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bfae_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfae_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_kind,
    input  logic [bfae_pkg::OFF_W-1:0]          s_bit_offset,
    input  logic [bfae_pkg::SIZE_W-1:0]         s_bit_size,
    input  logic [bfae_pkg::DATA_W-1:0]         s_write_value,
    input  bfae_pkg::bfae_cmd_t                 cmd,
    output bfae_pkg::bfae_sts_t                 sts,
    output logic [bfae_pkg::DATA_W-1:0]         m_read_value,
    output logic [bfae_pkg::STATUS_W-1:0]       m_status
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [15:0]   DEPTH_BYTES = 16'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(BUFFER_DEPTH - 1);

    // configuration
    logic       target_kind_reg;
    logic [8:0] buffer_bytes_reg;
    logic [6:0] integer_width_reg;

    // captured item
    logic                              kind_reg;
    logic [bfae_pkg::OFF_W-1:0]        off_reg;
    logic [bfae_pkg::SIZE_W-1:0]       size_reg;
    logic [bfae_pkg::DATA_W-1:0]       val_reg;

    logic [bfae_pkg::DATA_W-1:0]       integer_word_reg;
    logic [bfae_pkg::DATA_W-1:0]       integer_word_next;

    logic [7:0]                        mem [BUFFER_DEPTH];
    logic [7:0]                        rd_data_reg;
    logic [AW-1:0]                     clr_addr_reg;
    logic [AW-1:0]                     rd_addr_reg;
    logic [AW-1:0]                     wr_addr_reg;
    logic [bfae_pkg::NBYTES_W-1:0]     rd_left_reg;
    logic [bfae_pkg::NBYTES_W-1:0]     wr_left_reg;
    logic [bfae_pkg::NBYTES_W-1:0]     nbytes_reg;
    logic                              rdv_reg;
    logic [bfae_pkg::SPAN_W-1:0]       data_reg;
    logic [bfae_pkg::SPAN_W-1:0]       mask_reg;
    logic [bfae_pkg::SPAN_W-1:0]       acc_reg;

    logic [bfae_pkg::DATA_W-1:0]       res_reg;
    logic [bfae_pkg::STATUS_W-1:0]     st_reg;
    logic [bfae_pkg::DATA_W-1:0]       out_val_reg;
    logic [bfae_pkg::STATUS_W-1:0]     out_st_reg;

    logic [6:0]                        iw_eff;
    logic [6:0]                        size_limit;
    logic                              size_bad;
    logic                              range_bad;
    logic [12:0]                       end_sum;
    logic [12:0]                       last_bit;
    logic [15:0]                       bb_eff;
    logic [15:0]                       buf_bits;
    logic [bfae_pkg::STATUS_W-1:0]     status_c;
    logic [bfae_pkg::DATA_W-1:0]       fmask;
    logic [bfae_pkg::DATA_W-1:0]       int_ins_mask;
    logic [bfae_pkg::DATA_W-1:0]       int_read;
    logic [bfae_pkg::NBYTES_W-1:0]     nbytes_c;
    logic [AW-1:0]                     start_addr;
    logic [7:0]                        merged;
    logic [6:0]                        align_sh;
    logic [bfae_pkg::SPAN_W-1:0]       aligned;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [7:0]                        mem_wdata;
    logic                              rd_issue;

    always_comb begin
        if (integer_width_reg < bfae_pkg::INT_W_MIN) begin
            iw_eff = bfae_pkg::INT_W_MIN;
        end else if (integer_width_reg > bfae_pkg::INT_W_MAX) begin
            iw_eff = bfae_pkg::INT_W_MAX;
        end else begin
            iw_eff = integer_width_reg;
        end
        size_limit = (kind_reg == bfae_pkg::KIND_WRITE) ? iw_eff : 7'd64;
        size_bad   = (size_reg == '0) || (size_reg > size_limit);
        end_sum    = {1'b0, off_reg} + 13'(size_reg);
        bb_eff     = (16'(buffer_bytes_reg) > DEPTH_BYTES) ? DEPTH_BYTES
                                                           : 16'(buffer_bytes_reg);
        buf_bits   = {bb_eff[12:0], 3'b000};
        range_bad  = (target_kind_reg == bfae_pkg::TARGET_BYTE) ? (16'(end_sum) > buf_bits)
                                                                : (end_sum > 13'(iw_eff));
        if (size_bad) begin
            status_c = bfae_pkg::ST_SIZE;
        end else if (range_bad) begin
            status_c = bfae_pkg::ST_RANGE;
        end else begin
            status_c = bfae_pkg::ST_OK;
        end

        fmask        = bfae_pkg::low_mask(size_reg);
        last_bit     = end_sum - 13'd1;
        nbytes_c     = 4'(last_bit[12:3] - {1'b0, off_reg[11:3]} + 10'd1);
        start_addr   = AW'({3'b000, off_reg[11:3]});

        int_ins_mask      = fmask << off_reg[5:0];
        integer_word_next = (integer_word_reg & ~int_ins_mask)
                          | ((val_reg & fmask) << off_reg[5:0]);
        int_read          = (integer_word_reg >> off_reg[5:0]) & fmask;

        merged   = (rd_data_reg & ~mask_reg[7:0]) | (data_reg[7:0] & mask_reg[7:0]);
        align_sh = (7'd72 - {nbytes_reg, 3'b000}) + {4'b0000, off_reg[2:0]};
        aligned  = acc_reg >> align_sh;

        rd_issue  = cmd.byte_step && (rd_left_reg != '0);
        mem_we    = cmd.clear_step || (cmd.byte_step && rdv_reg
                                       && (kind_reg == bfae_pkg::KIND_WRITE));
        mem_waddr = cmd.clear_step ? clr_addr_reg : wr_addr_reg;
        mem_wdata = cmd.clear_step ? 8'h00 : merged;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_kind_reg   <= 1'b0;
            buffer_bytes_reg  <= bfae_pkg::BUF_BYTES_RST;
            integer_width_reg <= bfae_pkg::INT_W_RST;
            integer_word_reg  <= '0;
            clr_addr_reg      <= '0;
            rdv_reg           <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    bfae_pkg::CFG_TARGET_KIND:   target_kind_reg   <= cfg_wdata[0];
                    bfae_pkg::CFG_BUFFER_BYTES:  buffer_bytes_reg  <= cfg_wdata[8:0];
                    bfae_pkg::CFG_INTEGER_WIDTH: integer_width_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.int_op && (kind_reg == bfae_pkg::KIND_WRITE)) begin
                integer_word_reg <= integer_word_next;
            end
            if (cmd.check) begin
                rdv_reg <= 1'b0;
            end else if (cmd.byte_step) begin
                rdv_reg <= rd_issue;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= s_kind;
            off_reg  <= s_bit_offset;
            size_reg <= s_bit_size;
            val_reg  <= s_write_value;
        end
        if (cmd.check) begin
            st_reg      <= status_c;
            res_reg     <= '0;
            nbytes_reg  <= nbytes_c;
            rd_left_reg <= nbytes_c;
            wr_left_reg <= nbytes_c;
            rd_addr_reg <= start_addr;
            wr_addr_reg <= start_addr;
            data_reg    <= {8'h00, val_reg & fmask} << off_reg[2:0];
            mask_reg    <= {8'h00, fmask} << off_reg[2:0];
        end
        if (cmd.int_op && (kind_reg == bfae_pkg::KIND_READ)) begin
            res_reg <= int_read;
        end
        if (rd_issue) begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            rd_left_reg <= rd_left_reg - 1'b1;
        end
        if (cmd.byte_step && rdv_reg) begin
            wr_addr_reg <= wr_addr_reg + 1'b1;
            wr_left_reg <= wr_left_reg - 1'b1;
            data_reg    <= data_reg >> 8;
            mask_reg    <= mask_reg >> 8;
            acc_reg     <= {rd_data_reg, acc_reg[bfae_pkg::SPAN_W-1:8]};
        end
        if (cmd.align) begin
            res_reg <= aligned[bfae_pkg::DATA_W-1:0] & fmask;
        end
        if (cmd.load_out) begin
            out_val_reg <= res_reg;
            out_st_reg  <= st_reg;
        end
    end

    assign sts.clear_last  = (clr_addr_reg == LAST_ADDR);
    assign sts.bad         = (status_c != bfae_pkg::ST_OK);
    assign sts.byte_target = (target_kind_reg == bfae_pkg::TARGET_BYTE);
    assign sts.is_write    = (kind_reg == bfae_pkg::KIND_WRITE);
    assign sts.bytes_last  = rdv_reg && (wr_left_reg == 4'd1);

    assign m_read_value = out_val_reg;
    assign m_status     = out_st_reg;

endmodule

// File: sv/bit_field_access_engine.sv
// Bit-field insert/extract on a 64-bit integer register or a byte store of
// BUFFER_DEPTH bytes (LSB-first within each byte). After reset the store is
// swept to zero one byte per cycle, and s_ready stays low until the sweep
// is done; configuration writes are taken throughout. One transfer is worked
// at a time: a flagged access goes from the check straight to the result, an
// integer access passes through one insert/extract step, and a byte-store
// access steps through the n bytes that the field touches (n up to 9), one
// byte per cycle over the single byte-wide port pair of the store, which reads
// one byte and, on a write, writes back the previous one; a read then aligns.
// A finished result sits in an output register, so the next transfer is
// accepted while it waits for m_ready.
module bit_field_access_engine #(
    parameter int BUFFER_DEPTH = bfae_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bfae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfae_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [bfae_pkg::OFF_W-1:0]        s_bit_offset,
    input  logic [bfae_pkg::SIZE_W-1:0]       s_bit_size,
    input  logic [bfae_pkg::DATA_W-1:0]       s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bfae_pkg::DATA_W-1:0]       m_read_value,
    output logic [bfae_pkg::STATUS_W-1:0]     m_status
);

    bfae_pkg::bfae_cmd_t cmd;
    bfae_pkg::bfae_sts_t sts;

    bfae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bfae_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_kind        (s_kind),
        .s_bit_offset  (s_bit_offset),
        .s_bit_size    (s_bit_size),
        .s_write_value (s_write_value),
        .cmd           (cmd),
        .sts           (sts),
        .m_read_value  (m_read_value),
        .m_status      (m_status)
    );

endmodule

// File: sv/bfae_chk.sv
module bfae_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [bfae_pkg::DATA_W-1:0]       m_read_value,
    input logic [bfae_pkg::STATUS_W-1:0]     m_status
);

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted while one is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == bfae_pkg::ST_OK || m_status == bfae_pkg::ST_SIZE
                     || m_status == bfae_pkg::ST_RANGE))
        else $error("undefined status code");

    a_flagged_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bfae_pkg::ST_OK) |-> (m_read_value == '0))
        else $error("flagged access returned data");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind bit_field_access_engine bfae_chk u_bfae_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status)
);
